[rtl/core/mi3_pkg.sv]
// Shared types, widths and constants for the 3x3 matrix inverse.
// No dependencies; every other file in rtl/core refers to this package.
package mi3_pkg;

  localparam int ELEM_W = 32;   // element width, Q16.16
  localparam int FRAC   = 16;
  localparam int COF_W  = 65;   // exact cofactor, signed
  localparam int AMAG_W = 64;   // cofactor magnitude
  localparam int DET_W  = 97;   // exact determinant, signed
  localparam int DMAG_W = 96;   // determinant magnitude
  localparam int THR_W  = 31;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int QSTEPS = 32;   // quotient bits produced by the divider lanes

  // Pipeline positions (stage 0 is the accepting edge)
  localparam int PIPE_DEPTH = 40;  // valid bits; the last is at stage 39, the divider outputs
  localparam int SING_DEPTH = 34;  // singular flag from stage 6 to stage 39

  localparam logic [ADDR_W-1:0] REG_THRESHOLD = 3'd0;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;

  localparam elem_t ONE     = elem_t'(1) <<< FRAC;
  localparam elem_t SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic vld;
    logic sing;
  } tag_t;

endpackage

[rtl/core/matrix3_inverse_top.sv]
// 3x3 matrix inverse by the adjugate: a matrix enters on start every cycle
// (busy stays low) and its inverse appears on done, one word per accepted
// matrix in order, after the 32-stage quotient pipeline of the nine divider
// lanes. The receiver cannot stall.
module matrix3_inverse_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  mi3_pkg::elem_t               m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output mi3_pkg::elem_t               r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output logic                         singular,
  output logic                         done,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mi3_pkg::ADDR_W-1:0]   paddr,
  input  logic [mi3_pkg::DATA_W-1:0]   pwdata,
  output logic [mi3_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [mi3_pkg::THR_W-1:0]      thr;
  logic [mi3_pkg::PIPE_DEPTH-1:0] vld;
  logic [mi3_pkg::SING_DEPTH-1:0] sing_pipe;

  mi3_pkg::elem_t e_d1 [3];
  mi3_pkg::elem_t e_d2 [3];
  mi3_pkg::cof_t  cof  [9];
  mi3_pkg::cof_t  adj1 [9];
  mi3_pkg::cof_t  adj2 [9];
  mi3_pkg::cof_t  adj3 [9];
  logic signed [mi3_pkg::COF_W-1:0] plo  [3];
  logic signed [mi3_pkg::COF_W-1:0] phi  [3];
  logic signed [mi3_pkg::DET_W-1:0] term [3];
  logic signed [mi3_pkg::DET_W-1:0] det;
  logic [mi3_pkg::DMAG_W-1:0]       dmag;
  logic [mi3_pkg::AMAG_W-1:0]       amag [9];
  logic                             aneg [9];
  mi3_pkg::elem_t quot [9];
  mi3_pkg::elem_t res  [9];
  mi3_pkg::tag_t  tag;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= mi3_pkg::THR_W'(1);
    end else if (psel && penable && pwrite && paddr == mi3_pkg::REG_THRESHOLD) begin
      thr <= pwdata[mi3_pkg::THR_W-1:0];
    end
  end

  assign prdata = (paddr == mi3_pkg::REG_THRESHOLD) ? {1'b0, thr} : '0;

  // Cofactor lanes, laid out as the adjugate (transposed cofactors)
  mi3_cof_lane u_c0 (.clk, .x(m11), .y(m22), .u(m12), .v(m21), .cof(cof[0]));
  mi3_cof_lane u_c1 (.clk, .x(m02), .y(m21), .u(m01), .v(m22), .cof(cof[1]));
  mi3_cof_lane u_c2 (.clk, .x(m01), .y(m12), .u(m02), .v(m11), .cof(cof[2]));
  mi3_cof_lane u_c3 (.clk, .x(m12), .y(m20), .u(m10), .v(m22), .cof(cof[3]));
  mi3_cof_lane u_c4 (.clk, .x(m00), .y(m22), .u(m02), .v(m20), .cof(cof[4]));
  mi3_cof_lane u_c5 (.clk, .x(m02), .y(m10), .u(m00), .v(m12), .cof(cof[5]));
  mi3_cof_lane u_c6 (.clk, .x(m10), .y(m21), .u(m11), .v(m20), .cof(cof[6]));
  mi3_cof_lane u_c7 (.clk, .x(m01), .y(m20), .u(m00), .v(m21), .cof(cof[7]));
  mi3_cof_lane u_c8 (.clk, .x(m00), .y(m11), .u(m01), .v(m10), .cof(cof[8]));

  // Determinant along the first row; each 32 x 65 product is split in two
  // halves that are multiplied separately and recombined a stage later.
  always_ff @(posedge clk) begin
    e_d1[0] <= m00;
    e_d1[1] <= m01;
    e_d1[2] <= m02;
    e_d2    <= e_d1;
    for (int k = 0; k < 3; k++) begin
      plo[k]  <= e_d2[k] * $signed({1'b0, cof[3*k][31:0]});
      phi[k]  <= e_d2[k] * $signed(cof[3*k][mi3_pkg::COF_W-1:32]);
      term[k] <= $signed({phi[k], 32'b0}) + mi3_pkg::DET_W'(plo[k]);
    end
    det  <= term[0] + term[1] + term[2];
    adj1 <= cof;
    adj2 <= adj1;
    adj3 <= adj2;
    dmag <= det[mi3_pkg::DET_W-1] ? mi3_pkg::DMAG_W'(-det) : mi3_pkg::DMAG_W'(det);
    for (int i = 0; i < 9; i++) begin
      amag[i] <= adj3[i][mi3_pkg::COF_W-1] ? mi3_pkg::AMAG_W'(-adj3[i])
                                          : mi3_pkg::AMAG_W'(adj3[i]);
      aneg[i] <= adj3[i][mi3_pkg::COF_W-1] ^ det[mi3_pkg::DET_W-1];
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_div
    mi3_div_lane u_div (
      .clk,
      .a    (amag[i]),
      .d    (dmag),
      .neg  (aneg[i]),
      .quot (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    sing_pipe <= {sing_pipe[mi3_pkg::SING_DEPTH-2:0],
                  (dmag == '0) || (dmag < mi3_pkg::DMAG_W'({thr, 32'b0}))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[mi3_pkg::PIPE_DEPTH-2:0], start && !busy};
    end
  end

  assign tag.vld  = vld[mi3_pkg::PIPE_DEPTH-1];
  assign tag.sing = sing_pipe[mi3_pkg::SING_DEPTH-1];

  mi3_merge u_merge (
    .clk,
    .rst,
    .tag,
    .quot,
    .res,
    .singular,
    .done
  );

  assign r00 = res[0];
  assign r01 = res[1];
  assign r02 = res[2];
  assign r10 = res[3];
  assign r11 = res[4];
  assign r12 = res[5];
  assign r20 = res[6];
  assign r21 = res[7];
  assign r22 = res[8];

`ifndef ASSERT_OFF
  a_identity: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> r00 == mi3_pkg::ONE && r11 == mi3_pkg::ONE &&
      r22 == mi3_pkg::ONE && r01 == '0 && r10 == '0 && r20 == '0)
    else $error("singular word is not the identity");
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    !$past(start, mi3_pkg::PIPE_DEPTH + 1) |-> !done)
    else $error("word delivered without a matching start");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("word delivered straight after reset");
`endif

endmodule

[rtl/core/mi3_cof_lane.sv]
// One cofactor lane: x*y - u*v formed exactly over two register stages.
// Depends on mi3_pkg.
module mi3_cof_lane (
  input  logic           clk,
  input  mi3_pkg::elem_t x,
  input  mi3_pkg::elem_t y,
  input  mi3_pkg::elem_t u,
  input  mi3_pkg::elem_t v,
  output mi3_pkg::cof_t  cof
);

  logic signed [2*mi3_pkg::ELEM_W-1:0] pxy;
  logic signed [2*mi3_pkg::ELEM_W-1:0] puv;

  always_ff @(posedge clk) begin
    pxy <= x * y;
    puv <= u * v;
    cof <= mi3_pkg::COF_W'(pxy) - mi3_pkg::COF_W'(puv);
  end

endmodule

[rtl/core/mi3_div_lane.sv]
// Divider lane: trunc(a * 2^32 / d) saturated to the element range, one
// quotient bit per stage. Depends on mi3_pkg.
module mi3_div_lane (
  input  logic                        clk,
  input  logic [mi3_pkg::AMAG_W-1:0]  a,
  input  logic [mi3_pkg::DMAG_W-1:0]  d,
  input  logic                        neg,
  output mi3_pkg::elem_t              quot
);

  logic [mi3_pkg::DMAG_W-1:0] rem  [mi3_pkg::QSTEPS+1];
  logic [mi3_pkg::DMAG_W-1:0] dv   [mi3_pkg::QSTEPS+1];
  logic [mi3_pkg::QSTEPS-1:0] q    [mi3_pkg::QSTEPS+1];
  logic                       ovf  [mi3_pkg::QSTEPS+1];
  logic                       sgn  [mi3_pkg::QSTEPS+1];
  logic                       over;

  // When a >= d the quotient is at least 2^32 and saturates whatever follows;
  // otherwise the remainder starts below d and 32 steps give the whole quotient.
  always_ff @(posedge clk) begin
    ovf[0] <= mi3_pkg::DMAG_W'(a) >= d;
    rem[0] <= mi3_pkg::DMAG_W'(a);
    dv[0]  <= d;
    q[0]   <= '0;
    sgn[0] <= neg;
  end

  for (genvar k = 1; k <= mi3_pkg::QSTEPS; k++) begin : g_step
    logic [mi3_pkg::DMAG_W+1:0] diff;
    assign diff = {1'b0, rem[k-1], 1'b0} - {2'b00, dv[k-1]};
    always_ff @(posedge clk) begin
      if (!diff[mi3_pkg::DMAG_W+1]) begin
        rem[k] <= diff[mi3_pkg::DMAG_W-1:0];
      end else begin
        rem[k] <= {rem[k-1][mi3_pkg::DMAG_W-2:0], 1'b0};
      end
      q[k]   <= {q[k-1][mi3_pkg::QSTEPS-2:0], !diff[mi3_pkg::DMAG_W+1]};
      dv[k]  <= dv[k-1];
      ovf[k] <= ovf[k-1];
      sgn[k] <= sgn[k-1];
    end
  end

  always_comb begin
    if (sgn[mi3_pkg::QSTEPS]) begin
      over = ovf[mi3_pkg::QSTEPS] ||
             (q[mi3_pkg::QSTEPS] > mi3_pkg::QSTEPS'(mi3_pkg::SAT_NEG));
    end else begin
      over = ovf[mi3_pkg::QSTEPS] || q[mi3_pkg::QSTEPS][mi3_pkg::QSTEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (sgn[mi3_pkg::QSTEPS]) begin
      quot <= over ? mi3_pkg::SAT_NEG : -mi3_pkg::elem_t'(q[mi3_pkg::QSTEPS]);
    end else begin
      quot <= over ? mi3_pkg::SAT_POS : mi3_pkg::elem_t'(q[mi3_pkg::QSTEPS]);
    end
  end

endmodule

[rtl/core/mi3_merge.sv]
// Merging stage: collects the nine lane quotients, substitutes the identity
// for a singular matrix and registers the result word. Depends on mi3_pkg.
module mi3_merge (
  input  logic           clk,
  input  logic           rst,
  input  mi3_pkg::tag_t  tag,
  input  mi3_pkg::elem_t quot [9],
  output mi3_pkg::elem_t res  [9],
  output logic           singular,
  output logic           done
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    singular <= tag.sing;
    for (int i = 0; i < 9; i++) begin
      if (tag.sing) begin
        res[i] <= (i % 4 == 0) ? mi3_pkg::ONE : '0;
      end else begin
        res[i] <= quot[i];
      end
    end
  end

endmodule
